>>> hw/rtl/sogf_pkg.sv
package sogf_pkg;

    // default values of the top level parameters
    localparam int FOLLOWER_STAGES_DEF = 10;
    localparam int SAMPLE_BITS_DEF     = 24;
    localparam int CHANNELS_DEF        = 2;

    // internal word widths
    localparam int WW     = 56;   // product after shift, sums of products
    localparam int OPA_W  = 42;   // multiplier operand a
    localparam int OPB_W  = 33;   // multiplier operand b
    localparam int ALO_W  = 21;   // low part of operand a
    localparam int ZW     = 40;   // filter memories and wide signals
    localparam int GW     = 32;   // gains and followers
    localparam int QBITS  = 25;   // quotient bits of the gain division
    localparam int DEN_W  = 41;   // divisor width
    localparam int REM_W  = 66;   // remainder width
    localparam int GN_W   = 15;   // gain noise width

    // noise generator
    localparam logic [31:0] SEED_RESET   = 32'h0042_6486;
    localparam logic [31:0] LCG_MUL      = 32'd1664525;
    localparam logic [31:0] LCG_ADD      = 32'd1013904223;
    localparam logic signed [31:0] NOISE_MUL    = 32'sd66;
    localparam logic signed [31:0] LO_NOISE_MUL = 32'sd336;

    // register reset values
    localparam logic [31:0]        PRE_GAIN_RST    = 32'd20132659;
    localparam logic [31:0]        POST_GAIN_RST   = 32'd15099494;
    localparam logic signed [31:0] COEFF_A_RST     = 32'sd1073207101;
    localparam logic signed [31:0] COEFF_B_RST     = -32'sd1072671304;
    localparam logic [30:0]        FOLLOW_RATE_RST = 31'd150646000;

    localparam logic signed [WW-1:0] Z_MAX = WW'((64'sd1 <<< (ZW - 1)) - 64'sd1);
    localparam logic signed [WW-1:0] Z_MIN = -Z_MAX - WW'(1);
    localparam logic signed [WW-1:0] G_MAX = WW'((64'sd1 <<< (GW - 1)) - 64'sd1);
    localparam logic signed [WW-1:0] G_MIN = -G_MAX - WW'(1);

    typedef enum logic [2:0] {
        REG_PRE_GAIN    = 3'd0,
        REG_POST_GAIN   = 3'd1,
        REG_COEFF_A     = 3'd2,
        REG_COEFF_B     = 3'd3,
        REG_FOLLOW_RATE = 3'd4
    } reg_idx_t;

    typedef enum logic {
        SH_24,
        SH_30
    } shift_sel_t;

    typedef enum logic [3:0] {
        L_IDLE,
        L_PRE,
        L_HPB,
        L_HPA,
        L_DIV,
        L_FOL,
        L_XN2,
        L_POST,
        L_HPB2,
        L_HPA2
    } lane_state_t;

    typedef struct packed {
        logic [31:0] pre_gain;
        logic [31:0] post_gain;
        logic [31:0] coeff_a;
        logic [31:0] coeff_b;
        logic [30:0] follow_rate;
    } cfg_t;

    function automatic logic signed [ZW-1:0] sat40(input logic signed [WW-1:0] v);
        logic signed [WW-1:0] r;
        if (v > Z_MAX) begin
            r = Z_MAX;
        end else if (v < Z_MIN) begin
            r = Z_MIN;
        end else begin
            r = v;
        end
        return r[ZW-1:0];
    endfunction

    function automatic logic signed [GW-1:0] sat32(input logic signed [WW-1:0] v);
        logic signed [WW-1:0] r;
        if (v > G_MAX) begin
            r = G_MAX;
        end else if (v < G_MIN) begin
            r = G_MIN;
        end else begin
            r = v;
        end
        return r[GW-1:0];
    endfunction

endpackage

>>> hw/rtl/sogf_mulsh.sv
module sogf_mulsh (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   start,
    input  logic signed [sogf_pkg::OPA_W-1:0]      op_a,
    input  logic signed [sogf_pkg::OPB_W-1:0]      op_b,
    input  sogf_pkg::shift_sel_t                   sh,
    output logic                                   done,
    output logic signed [sogf_pkg::WW-1:0]         res
);
    import sogf_pkg::*;

    localparam int AHI_W = OPA_W - ALO_W;
    localparam int PLO_W = ALO_W + 1 + OPB_W;
    localparam int PHI_W = AHI_W + OPB_W;
    localparam int FULL_W = OPA_W + OPB_W + 1;

    logic signed [PLO_W-1:0]  plo_reg, plo_next;
    logic signed [AHI_W-1:0]  ahi_reg;
    logic signed [OPB_W-1:0]  b_reg;
    shift_sel_t               sh_reg;
    logic                     busy_reg;
    logic                     done_reg;
    logic signed [WW-1:0]     res_reg, res_next;
    logic signed [PHI_W-1:0]  phi;
    logic signed [FULL_W-1:0] full;
    logic signed [FULL_W-1:0] shifted;

    // first partial product: unsigned low bits of a
    always_comb begin
        plo_next = $signed({1'b0, op_a[ALO_W-1:0]}) * op_b;
    end

    // second partial product and the sum, then the floor shift
    always_comb begin
        phi      = ahi_reg * b_reg;
        full     = (FULL_W'(phi) <<< ALO_W) + FULL_W'(plo_reg);
        shifted  = (sh_reg == SH_30) ? (full >>> 30) : (full >>> 24);
        res_next = shifted[WW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            plo_reg  <= '0;
            ahi_reg  <= '0;
            b_reg    <= '0;
            sh_reg   <= SH_24;
            res_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                plo_reg  <= plo_next;
                ahi_reg  <= op_a[OPA_W-1:ALO_W];
                b_reg    <= op_b;
                sh_reg   <= sh;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                res_reg  <= res_next;
                done_reg <= 1'b1;
                busy_reg <= 1'b0;
            end
        end
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule

>>> hw/rtl/sogf_div.sv
module sogf_div #(
    parameter int SAMPLE_BITS = sogf_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [sogf_pkg::DEN_W-1:0]    den,
    output logic                          done,
    output logic [sogf_pkg::QBITS-1:0]    q
);
    import sogf_pkg::*;

    localparam int FRAC = SAMPLE_BITS - 1;
    localparam int CW   = $clog2(QBITS);

    logic [REM_W-1:0] r_reg;
    logic [REM_W-1:0] d_reg;
    logic [QBITS-1:0] q_reg;
    logic [CW-1:0]    cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic             ge;

    assign ge = (r_reg >= d_reg);

    // restoring division, one quotient bit per cycle, msb first
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            r_reg    <= '0;
            d_reg    <= '0;
            q_reg    <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                r_reg    <= REM_W'(1) << (FRAC + 26);
                d_reg    <= REM_W'(den) << (QBITS - 1);
                q_reg    <= '0;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                r_reg   <= ge ? (r_reg - d_reg) : r_reg;
                q_reg   <= {q_reg[QBITS-2:0], ge};
                d_reg   <= d_reg >> 1;
                cnt_reg <= cnt_reg + CW'(1);
                if (cnt_reg == CW'(QBITS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign q    = q_reg;

endmodule

>>> hw/rtl/sogf_lane.sv
module sogf_lane #(
    parameter int SAMPLE_BITS     = sogf_pkg::SAMPLE_BITS_DEF,
    parameter int FOLLOWER_STAGES = sogf_pkg::FOLLOWER_STAGES_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  sogf_pkg::cfg_t                      cfg,
    input  logic                                start,
    input  logic signed [SAMPLE_BITS:0]         x,
    input  logic signed [sogf_pkg::GN_W-1:0]    gnoise,
    output logic                                fin,
    output logic signed [SAMPLE_BITS-1:0]       y
);
    import sogf_pkg::*;

    localparam int FRAC = SAMPLE_BITS - 1;
    localparam int FS   = FOLLOWER_STAGES;
    localparam int KW   = $clog2(FS);
    localparam logic signed [WW-1:0] Y_MAX = WW'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [WW-1:0] Y_MIN = -Y_MAX - WW'(1);

    lane_state_t              state_reg, state_next;
    logic                     wait_reg, wait_next;
    logic signed [SAMPLE_BITS:0] x_reg, x_next;
    logic signed [GN_W-1:0]   gn_reg, gn_next;
    logic signed [ZW-1:0]     z1_reg, z1_next;
    logic signed [ZW-1:0]     z2_reg, z2_next;
    logic signed [ZW-1:0]     p_reg, p_next;
    logic signed [ZW-1:0]     acc_reg, acc_next;
    logic signed [ZW-1:0]     xn1_reg, xn1_next;
    logic signed [ZW-1:0]     xn2_reg, xn2_next;
    logic signed [ZW-1:0]     acc2_reg, acc2_next;
    logic signed [WW-1:0]     t_reg, t_next;
    logic signed [GW-1:0]     prev_reg, prev_next;
    logic signed [GW-1:0]     st_reg [FS];
    logic signed [GW-1:0]     st_next [FS];
    logic [KW-1:0]            k_reg, k_next;
    logic signed [SAMPLE_BITS-1:0] y_reg, y_next;

    logic                     mul_start, mul_done;
    logic signed [OPA_W-1:0]  mul_a;
    logic signed [OPB_W-1:0]  mul_b;
    shift_sel_t               mul_sh;
    logic signed [WW-1:0]     mul_res;
    logic                     div_start, div_done;
    logic [DEN_W-1:0]         den;
    logic [QBITS-1:0]         div_q;

    logic signed [GW-1:0]     st_cur;
    logic signed [ZW:0]       xn1_ext;
    logic signed [ZW:0]       level;
    logic                     last_stage;
    logic signed [GW-1:0]     st_upd;
    logic signed [WW-1:0]     y_wide;

    sogf_mulsh u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .sh      (mul_sh),
        .done    (mul_done),
        .res     (mul_res)
    );

    sogf_div #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .den     (den),
        .done    (div_done),
        .q       (div_q)
    );

    assign st_cur     = st_reg[k_reg];
    assign last_stage = (k_reg == KW'(FS - 1));
    assign st_upd     = sat32(WW'(st_cur) + mul_res);

    // rectified level, positive half-waves at half weight
    always_comb begin
        xn1_ext = (ZW + 1)'(xn1_reg);
        level   = (xn1_reg > 0) ? (xn1_ext >>> 1) : -xn1_ext;
        den     = DEN_W'(64'd4 << FRAC) + DEN_W'(level);
    end

    // saturate the final filter output to the sample width
    always_comb begin
        if (mul_res > Y_MAX) begin
            y_wide = Y_MAX;
        end else if (mul_res < Y_MIN) begin
            y_wide = Y_MIN;
        end else begin
            y_wide = mul_res;
        end
    end

    // multiplier operands by step
    always_comb begin
        mul_a  = '0;
        mul_b  = '0;
        mul_sh = SH_24;
        unique case (state_reg)
            L_PRE: begin
                mul_a = OPA_W'(x_reg);
                mul_b = $signed({1'b0, cfg.pre_gain});
            end
            L_HPB: begin
                mul_a  = OPA_W'(z1_reg);
                mul_b  = OPB_W'($signed(cfg.coeff_b));
                mul_sh = SH_30;
            end
            L_HPA: begin
                mul_a  = OPA_W'((ZW + 1)'(acc_reg) - (ZW + 1)'(z1_reg));
                mul_b  = OPB_W'($signed(cfg.coeff_a));
                mul_sh = SH_30;
            end
            L_FOL: begin
                mul_a  = OPA_W'((GW + 1)'(prev_reg) - (GW + 1)'(st_cur));
                mul_b  = $signed({2'b00, cfg.follow_rate});
                mul_sh = SH_30;
            end
            L_XN2: begin
                mul_a = OPA_W'(xn1_reg);
                mul_b = OPB_W'(st_reg[FS-1]);
            end
            L_POST: begin
                mul_a = OPA_W'(xn2_reg);
                mul_b = $signed({1'b0, cfg.post_gain});
            end
            L_HPB2: begin
                mul_a  = OPA_W'(z2_reg);
                mul_b  = OPB_W'($signed(cfg.coeff_b));
                mul_sh = SH_30;
            end
            L_HPA2: begin
                mul_a  = OPA_W'((ZW + 1)'(acc2_reg) - (ZW + 1)'(z2_reg));
                mul_b  = OPB_W'($signed(cfg.coeff_a));
                mul_sh = SH_30;
            end
            default: begin
                mul_a = '0;
            end
        endcase
    end

    // step sequencer
    always_comb begin
        state_next = state_reg;
        wait_next  = wait_reg;
        x_next     = x_reg;
        gn_next    = gn_reg;
        z1_next    = z1_reg;
        z2_next    = z2_reg;
        p_next     = p_reg;
        acc_next   = acc_reg;
        xn1_next   = xn1_reg;
        xn2_next   = xn2_reg;
        acc2_next  = acc2_reg;
        t_next     = t_reg;
        prev_next  = prev_reg;
        st_next    = st_reg;
        k_next     = k_reg;
        y_next     = y_reg;
        mul_start  = 1'b0;
        div_start  = 1'b0;
        fin        = 1'b0;

        unique case (state_reg)
            L_IDLE: begin
                if (start) begin
                    x_next     = x;
                    gn_next    = gnoise;
                    wait_next  = 1'b0;
                    state_next = L_PRE;
                end
            end
            L_DIV: begin
                if (!wait_reg) begin
                    div_start = 1'b1;
                    wait_next = 1'b1;
                end else if (div_done) begin
                    prev_next  = sat32($signed(WW'(div_q)) + WW'(gn_reg));
                    k_next     = '0;
                    wait_next  = 1'b0;
                    state_next = L_FOL;
                end
            end
            L_FOL: begin
                if (!wait_reg) begin
                    // falls at once: no multiply needed
                    if (!last_stage && (prev_reg <= st_cur)) begin
                        st_next[k_reg] = prev_reg;
                        k_next         = k_reg + KW'(1);
                    end else begin
                        mul_start = 1'b1;
                        wait_next = 1'b1;
                    end
                end else if (mul_done) begin
                    st_next[k_reg] = st_upd;
                    prev_next      = st_upd;
                    wait_next      = 1'b0;
                    if (last_stage) begin
                        state_next = L_XN2;
                    end else begin
                        k_next = k_reg + KW'(1);
                    end
                end
            end
            default: begin
                if (!wait_reg) begin
                    mul_start = 1'b1;
                    wait_next = 1'b1;
                end else if (mul_done) begin
                    wait_next = 1'b0;
                    unique case (state_reg)
                        L_PRE: begin
                            p_next     = sat40(mul_res);
                            state_next = L_HPB;
                        end
                        L_HPB: begin
                            acc_next   = sat40(WW'(p_reg) - mul_res);
                            state_next = L_HPA;
                        end
                        L_HPA: begin
                            xn1_next   = sat40(mul_res);
                            z1_next    = acc_reg;
                            state_next = L_DIV;
                        end
                        L_XN2: begin
                            xn2_next   = sat40(mul_res);
                            state_next = L_POST;
                        end
                        L_POST: begin
                            t_next     = mul_res;
                            state_next = L_HPB2;
                        end
                        L_HPB2: begin
                            acc2_next  = sat40(t_reg - mul_res);
                            state_next = L_HPA2;
                        end
                        L_HPA2: begin
                            y_next     = y_wide[SAMPLE_BITS-1:0];
                            z2_next    = acc2_reg;
                            fin        = 1'b1;
                            state_next = L_IDLE;
                        end
                        default: begin
                            state_next = L_IDLE;
                        end
                    endcase
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= L_IDLE;
            wait_reg  <= 1'b0;
            z1_reg    <= '0;
            z2_reg    <= '0;
            k_reg     <= '0;
            for (int i = 0; i < FS; i++) begin
                st_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            wait_reg  <= wait_next;
            z1_reg    <= z1_next;
            z2_reg    <= z2_next;
            k_reg     <= k_next;
            st_reg    <= st_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg    <= x_next;
        gn_reg   <= gn_next;
        p_reg    <= p_next;
        acc_reg  <= acc_next;
        xn1_reg  <= xn1_next;
        xn2_reg  <= xn2_next;
        acc2_reg <= acc2_next;
        t_reg    <= t_next;
        prev_reg <= prev_next;
        y_reg    <= y_next;
    end

    assign y = y_reg;

endmodule

>>> hw/rtl/stereo_overdrive_gain_follower_core.sv
// sequencing: each lane's sequencer runs the gain divider and between 8 and
//   FOLLOWER_STAGES + 7 two-stage multiplies per sample pair
// flow: one sample pair at a time; a new pair is taken
//   as soon as the previous result sits in the output register
// reset: synchronous active-low aresetn clears filter memories, followers,
//   noise seed and registers to their defaults; no clearing pass
module stereo_overdrive_gain_follower_core #(
    parameter int FOLLOWER_STAGES = sogf_pkg::FOLLOWER_STAGES_DEF,
    parameter int SAMPLE_BITS     = sogf_pkg::SAMPLE_BITS_DEF,
    parameter int CHANNELS        = sogf_pkg::CHANNELS_DEF,
    localparam int TDATA_W        = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic               aclk,
    input  logic               aresetn,
    // input stream
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [TDATA_W-1:0] s_tdata,   // left_in, right_in
    input  logic               s_tlast,   // block_end
    // result stream
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,   // left_out, right_out
    output logic               m_tlast,   // block_end_out
    // register port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import sogf_pkg::*;

    localparam int SB       = SAMPLE_BITS;
    localparam int FRAC     = SB - 1;
    localparam int LO_SHIFT = 49 - FRAC;
    localparam int LANES    = (CHANNELS < 2) ? CHANNELS : 2;
    // a missing second lane counts as finished
    localparam logic [1:0] LANE_ABSENT = (LANES < 2) ? 2'b10 : 2'b00;

    // configuration registers
    cfg_t cfg_reg;

    // control
    logic                 busy_reg;    // a pair is in the lanes or waits for output
    logic                 go_reg;      // start pulse to the lanes
    logic [31:0]          seed_reg;
    logic signed [SB-1:0] in_l_reg, in_r_reg;
    logic                 last_reg;
    logic [1:0]           fin_mask_reg;

    // output register
    logic                 m_valid_reg;
    logic signed [SB-1:0] out_l_reg, out_r_reg;
    logic                 out_last_reg;

    logic                 s_accept;
    logic                 cfg_write;
    reg_idx_t             cfg_idx;
    logic                 all_fin;
    logic                 load;

    // noise from the current seed
    logic signed [22:0]   noise_d;
    logic signed [31:0]   gprod, lprod, lshift;
    logic signed [GN_W-1:0] gnoise;
    logic signed [SB-1:0] lonoise;

    logic signed [SB:0]   lane_x [2];
    logic signed [SB-1:0] lane_y [2];
    logic [1:0]           lane_fin;

    assign s_tready  = !busy_reg;
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_idx   = reg_idx_t'(paddr[4:2]);
    assign pready    = 1'b1;

    // centered mantissa bits of the seed
    always_comb begin
        noise_d = $signed({~seed_reg[22], seed_reg[21:0]});
        gprod   = 32'(noise_d) * NOISE_MUL;
        lprod   = 32'(noise_d) * LO_NOISE_MUL;
        gnoise  = GN_W'(gprod >>> 16);
        lshift  = lprod >>> LO_SHIFT;
        lonoise = lshift[SB-1:0];
    end

    // tiny noise added to both inputs
    assign lane_x[0] = (SB + 1)'(in_l_reg) + (SB + 1)'(lonoise);
    assign lane_x[1] = (SB + 1)'(in_r_reg) + (SB + 1)'(lonoise);

    // one lane per carried channel, each with its own multiplier and divider
    for (genvar c = 0; c < 2; c++) begin : g_lane
        if (c < LANES) begin : g_on
            sogf_lane #(
                .SAMPLE_BITS     (SAMPLE_BITS),
                .FOLLOWER_STAGES (FOLLOWER_STAGES)
            ) u_lane (
                .aclk    (aclk),
                .aresetn (aresetn),
                .cfg     (cfg_reg),
                .start   (go_reg),
                .x       (lane_x[c]),
                .gnoise  (gnoise),
                .fin     (lane_fin[c]),
                .y       (lane_y[c])
            );
        end else begin : g_off
            // channel beyond the configured count gives zero
            assign lane_fin[c] = 1'b0;
            assign lane_y[c]   = '0;
        end
    end

    // merge: wait for every lane and a free output register, then move the pair into it
    assign all_fin = ((fin_mask_reg | LANE_ABSENT) == 2'b11);
    assign load    = busy_reg && all_fin && (!m_valid_reg || m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg     <= 1'b0;
            go_reg       <= 1'b0;
            seed_reg     <= SEED_RESET;
            fin_mask_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            go_reg <= 1'b0;
            if (s_accept) begin
                busy_reg <= 1'b1;
                go_reg   <= 1'b1;
                seed_reg <= seed_reg * LCG_MUL + LCG_ADD;
            end
            if (load) begin
                busy_reg     <= 1'b0;
                fin_mask_reg <= '0;
                m_valid_reg  <= 1'b1;
            end else begin
                fin_mask_reg <= fin_mask_reg | lane_fin;
                if (m_tready) begin
                    m_valid_reg <= 1'b0;
                end
            end
        end
    end

    // payload capture
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_l_reg <= s_tdata[SB-1:0];
            in_r_reg <= s_tdata[2*SB-1:SB];
            last_reg <= s_tlast;
        end
        if (load) begin
            out_l_reg    <= lane_y[0];
            out_r_reg    <= lane_y[1];
            out_last_reg <= last_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = TDATA_W'({out_r_reg, out_l_reg});
    assign m_tlast  = out_last_reg;

    // register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pre_gain    <= PRE_GAIN_RST;
            cfg_reg.post_gain   <= POST_GAIN_RST;
            cfg_reg.coeff_a     <= COEFF_A_RST;
            cfg_reg.coeff_b     <= COEFF_B_RST;
            cfg_reg.follow_rate <= FOLLOW_RATE_RST;
        end else if (cfg_write) begin
            case (cfg_idx)
                REG_PRE_GAIN:    cfg_reg.pre_gain    <= pwdata;
                REG_POST_GAIN:   cfg_reg.post_gain   <= pwdata;
                REG_COEFF_A:     cfg_reg.coeff_a     <= pwdata;
                REG_COEFF_B:     cfg_reg.coeff_b     <= pwdata;
                REG_FOLLOW_RATE: cfg_reg.follow_rate <= pwdata[30:0];
                default: begin
                end
            endcase
        end
    end

    // register reads
    always_comb begin
        case (cfg_idx)
            REG_PRE_GAIN:    prdata = cfg_reg.pre_gain;
            REG_POST_GAIN:   prdata = cfg_reg.post_gain;
            REG_COEFF_A:     prdata = cfg_reg.coeff_a;
            REG_COEFF_B:     prdata = cfg_reg.coeff_b;
            REG_FOLLOW_RATE: prdata = {1'b0, cfg_reg.follow_rate};
            default:         prdata = '0;
        endcase
    end

`ifndef SYNTH
    // lane completions are only collected while a pair is in flight
    a_fin_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !busy_reg |-> (fin_mask_reg == 2'b00))
        else $error("lane finished with no pair in flight");

    // every accepted pair advances the noise generator
    a_seed_step: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> (seed_reg != $past(seed_reg)))
        else $error("noise seed did not advance");

    // a result appears only after all lanes have finished
    a_out_after_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !$past(m_valid_reg)) |-> $past(all_fin && busy_reg))
        else $error("result loaded before lanes finished");

    // the lanes are only started within a fresh transaction, before any lane has finished
    a_go_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        go_reg |-> (busy_reg && (fin_mask_reg == 2'b00)))
        else $error("lane start outside a fresh transaction");
`endif

endmodule

>>> sim/sogf_checker.sv
module sogf_checker #(
    parameter int STAGES = 10,
    parameter int SBITS  = 24,
    parameter int TW     = 48
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    input  logic          s_tready,
    input  logic [TW-1:0] s_tdata,
    input  logic          s_tlast,
    input  logic          m_tvalid,
    input  logic          m_tready,
    input  logic [TW-1:0] m_tdata,
    input  logic          m_tlast,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [4:0]    paddr,
    input  logic [31:0]   pwdata,
    output int            fail_count,
    output int            pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import sogf_pkg::*;

    typedef struct packed {
        logic [SBITS-1:0] left;
        logic [SBITS-1:0] right;
        logic             last;
    } pair_t;

    pair_t expected_q[$];

    logic [31:0]    seed;
    longint         hp_in[2];
    longint         hp_out[2];
    longint         fol[2][STAGES];
    longint         c_pre, c_post, c_a, c_b, c_rate;

    function automatic longint clip(longint v, int bits);
        longint hi;
        hi = (longint'(1) <<< (bits - 1)) - 1;
        return v > hi ? hi : (v < -hi - 1 ? -hi - 1 : v);
    endfunction

    // floor(a*b / 2^sh) with enough width for the block's operands
    function automatic longint mul_shift(longint a, longint b, int sh);
        logic signed [127:0] p;
        p = 128'(a) * 128'(b);
        return longint'(p >>> sh);
    endfunction

    function automatic longint process_channel(int c, longint x, longint gnoise);
        longint p, acc, xn1, level, g, prev, xn2, acc2, z1, z2;
        logic [63:0] num, den;
        z1 = hp_in[c];
        z2 = hp_out[c];
        p = clip(mul_shift(x, c_pre, 24), 40);
        acc = clip(p - mul_shift(z1, c_b, 30), 40);
        xn1 = clip(mul_shift(acc - z1, c_a, 30), 40);
        hp_in[c] = acc;
        level = xn1 > 0 ? (xn1 >>> 1) : -xn1;
        num = 64'd4 << (24 + SBITS - 1);
        den = (64'd4 << (SBITS - 1)) + 64'(level);
        g = longint'(num / den);
        g = clip(g + gnoise, 32);
        prev = g;
        // the first STAGES - 1 followers: drop at once, rise slowly
        for (int k = 0; k + 1 < STAGES; k++) begin
            if (prev <= fol[c][k]) begin
                fol[c][k] = prev;
            end else begin
                fol[c][k] = clip(fol[c][k] + mul_shift(prev - fol[c][k], c_rate, 30), 32);
            end
            prev = fol[c][k];
        end
        fol[c][STAGES-1] = clip(fol[c][STAGES-1]
            + mul_shift(prev - fol[c][STAGES-1], c_rate, 30), 32);
        xn2 = clip(mul_shift(xn1, fol[c][STAGES-1], 24), 40);
        acc2 = clip(mul_shift(xn2, c_post, 24) - mul_shift(z2, c_b, 30), 40);
        hp_out[c] = acc2;
        return clip(mul_shift(acc2 - z2, c_a, 30), SBITS);
    endfunction

    function automatic pair_t predict_pair(logic [TW-1:0] data, logic last);
        longint d, gn, lo, xl, xr;
        pair_t r;
        seed = seed * LCG_MUL + LCG_ADD;
        d = longint'(seed & 32'h007f_ffff) - (longint'(1) <<< 22);
        gn = (d * 66) >>> 16;
        lo = (d * 336) >>> (49 - (SBITS - 1));
        xl = longint'($signed(data[SBITS-1:0]));
        xr = longint'($signed(data[2*SBITS-1:SBITS]));
        r.left = SBITS'(process_channel(0, xl + lo, gn));
        r.right = SBITS'(process_channel(1, xr + lo, gn));
        r.last = last;
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
        fail_count++;
    endtask

    assign pending = expected_q.size();

    always @(posedge aclk) begin
        pair_t e;
        if (!aresetn) begin
            seed = SEED_RESET;
            hp_in = '{0, 0};
            hp_out = '{0, 0};
            fol = '{default: 0};
            c_pre = PRE_GAIN_RST;
            c_post = POST_GAIN_RST;
            c_a = longint'(COEFF_A_RST);
            c_b = longint'(COEFF_B_RST);
            c_rate = FOLLOW_RATE_RST;
            expected_q.delete();
        end else begin
            if (psel && penable && pwrite) begin
                case (reg_idx_t'(paddr[4:2]))
                    REG_PRE_GAIN:    c_pre = longint'(pwdata);
                    REG_POST_GAIN:   c_post = longint'(pwdata);
                    REG_COEFF_A:     c_a = longint'($signed(pwdata));
                    REG_COEFF_B:     c_b = longint'($signed(pwdata));
                    REG_FOLLOW_RATE: c_rate = longint'(pwdata[30:0]);
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                if (expected_q.size() == 0) begin
                    report_mismatch("unexpected transaction", 0, 0);
                end else begin
                    e = expected_q.pop_front();
                    if (m_tdata[SBITS-1:0] !== e.left)
                        report_mismatch("left", $signed(m_tdata[SBITS-1:0]), $signed(e.left));
                    if (m_tdata[2*SBITS-1:SBITS] !== e.right)
                        report_mismatch("right", $signed(m_tdata[2*SBITS-1:SBITS]),
                                        $signed(e.right));
                    if (m_tlast !== e.last)
                        report_mismatch("last", m_tlast, e.last);
                end
            end
            if (s_tvalid && s_tready) begin
                expected_q.push_back(predict_pair(s_tdata, s_tlast));
            end
        end
    end

    initial fail_count = 0;
endmodule

>>> sim/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import sogf_pkg::*;

    localparam int TW = 48;
    localparam int LIMIT = 2_000_000;

    logic          aclk = 0;
    logic          aresetn = 0;
    logic          s_tvalid = 0;
    logic          s_tready;
    logic [TW-1:0] s_tdata = '0;   // left_in, right_in
    logic          s_tlast = 0;    // block_end
    logic          m_tvalid;
    logic          m_tready = 0;
    logic [TW-1:0] m_tdata;        // left_out, right_out
    logic          m_tlast;        // block_end_out
    logic          psel = 0, penable = 0, pwrite = 0;
    logic [4:0]    paddr = '0;
    logic [31:0]   pwdata = '0;
    logic [31:0]   prdata;
    logic          pready;
    int            fail_count, pending;
    int            cycles = 0;
    int            stall_left = 0;
    bit            sink_hold = 0;

    stereo_overdrive_gain_follower_core dut (.*);

    sogf_checker #(.STAGES(10), .SBITS(24), .TW(TW)) scoreboard (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_tdata, .s_tlast,
        .m_tvalid, .m_tready, .m_tdata, .m_tlast,
        .psel, .penable, .pwrite, .paddr, .pwdata,
        .fail_count, .pending
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // cycle watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic int gap_len();
        if ($urandom_range(0, 19) == 0) return $urandom_range(20, 150);
        return $urandom_range(0, 3) == 0 ? $urandom_range(1, 4) : 0;
    endfunction

    // result side backpressure: mostly short stalls, sometimes long ones
    always @(posedge aclk) begin
        int s;
        if (sink_hold) begin
            m_tready   <= 1;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            m_tready   <= 0;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 3) == 0) begin
            s = gap_len();
            m_tready   <= (s == 0);
            stall_left <= (s > 0) ? s - 1 : 0;
        end else begin
            m_tready <= 1;
        end
    end

    task automatic write_reg(reg_idx_t idx, logic [31:0] val);
        @(posedge aclk);
        psel <= 1; penable <= 0; pwrite <= 1;
        paddr <= {idx, 2'b00}; pwdata <= val;
        @(posedge aclk);
        penable <= 1;
        @(posedge aclk);
        psel <= 0; penable <= 0; pwrite <= 0;
    endtask

    // one input transaction, then an optional idle gap
    task automatic send_pair(logic signed [23:0] l, logic signed [23:0] r, logic last,
                             bit gaps);
        int g;
        @(posedge aclk);
        s_tvalid <= 1;
        s_tdata <= {r, l};
        s_tlast <= last;
        do @(posedge aclk); while (!s_tready);
        g = gaps ? gap_len() : 0;
        if (g > 0) begin
            s_tvalid <= 0;
            repeat (g - 1) @(posedge aclk);
        end else begin
            s_tvalid <= 0;
        end
    endtask

    // hold off until the block has drained, then its latency more
    task automatic drain();
        while (pending != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
    endtask

    function automatic logic signed [23:0] rand_sample();
        case ($urandom_range(0, 5))
            0: return 24'sh7fffff;
            1: return 24'sh800000;
            2: return 24'($signed($urandom_range(0, 2000)) - 1000);
            default: return 24'($urandom);
        endcase
    endfunction

    task automatic random_phase(int n, bit full_swing);
        logic signed [23:0] l, r;
        for (int i = 0; i < n; i++) begin
            if (full_swing) begin
                l = rand_sample();
                r = rand_sample();
            end else begin
                // sawtooth ramps keep the followers moving
                l = 24'($signed(i * 40000) % 4000000);
                r = -l + 24'($signed($urandom_range(0, 255)));
            end
            send_pair(l, r, $urandom_range(0, 7) == 0, (i % 50) < 35);
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1;

        // directed: extremes, block marks, silence, steps
        send_pair(24'sh7fffff, 24'sh800000, 1, 0);
        send_pair(24'sh800000, 24'sh7fffff, 0, 0);
        send_pair(0, 0, 0, 1);
        send_pair(24'sh7fffff, 24'sh7fffff, 1, 1);
        send_pair(24'sh800000, 24'sh800000, 0, 0);
        send_pair(24'sh555555, 24'shaaaaaa, 1, 0);
        send_pair(24'shaaaaaa, 24'sh555555, 0, 1);
        for (int i = 0; i < 8; i++) send_pair(0, 0, i[0], 0);
        for (int i = 0; i < 6; i++) send_pair(24'sh400000, -24'sh400000, 0, 0);
        // sender waits for every result before going on
        drain();

        random_phase(250, 1);
        drain();

        // strong drive, extreme coefficients
        write_reg(REG_PRE_GAIN, 32'hffff_ffff);
        write_reg(REG_POST_GAIN, 32'hffff_ffff);
        write_reg(REG_COEFF_A, 32'h7fff_ffff);
        write_reg(REG_COEFF_B, 32'h8000_0000);
        write_reg(REG_FOLLOW_RATE, 32'h4000_0000);
        random_phase(150, 1);
        drain();

        // all zero
        write_reg(REG_PRE_GAIN, 0);
        write_reg(REG_POST_GAIN, 0);
        write_reg(REG_COEFF_A, 0);
        write_reg(REG_COEFF_B, 0);
        write_reg(REG_FOLLOW_RATE, 0);
        random_phase(60, 1);
        drain();

        // random gains and follow rate, extreme coefficients, softer stimulus
        write_reg(REG_PRE_GAIN, $urandom_range(0, 32'h0400_0000));
        write_reg(REG_POST_GAIN, $urandom);
        write_reg(REG_COEFF_A, 32'h8000_0000);
        write_reg(REG_COEFF_B, 32'h7fff_ffff);
        write_reg(REG_FOLLOW_RATE, $urandom_range(1, 32'h0800_0000));
        random_phase(200, 0);
        drain();

        // back to defaults for the final stretch, first with no sink stalls
        write_reg(REG_PRE_GAIN, PRE_GAIN_RST);
        write_reg(REG_POST_GAIN, POST_GAIN_RST);
        write_reg(REG_COEFF_A, COEFF_A_RST);
        write_reg(REG_COEFF_B, COEFF_B_RST);
        write_reg(REG_FOLLOW_RATE, 32'(FOLLOW_RATE_RST));
        sink_hold = 1;
        random_phase(100, 0);
        sink_hold = 0;
        random_phase(180, 1);

        drain();
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule

>>> sim.f
hw/rtl/sogf_pkg.sv
hw/rtl/sogf_mulsh.sv
hw/rtl/sogf_div.sv
hw/rtl/sogf_lane.sv
hw/rtl/stereo_overdrive_gain_follower_core.sv
sim/sogf_checker.sv
sim/testbench.sv
